// ===== rtl/core/stok_pkg.sv =====
package stok_pkg;

    // Default longest word, counted in bytes including the one that overflows.
    localparam int MAX_WORD_DEF = 256;

    // Result queue geometry: room for two full items.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef logic [3:0] t_kind;
    typedef logic [1:0] t_pend;

    // Result kinds.
    localparam t_kind K_WORD_BYTE = 4'd0;
    localparam t_kind K_WORD_END  = 4'd1;
    localparam t_kind K_SEMI      = 4'd2;
    localparam t_kind K_AMP       = 4'd3;
    localparam t_kind K_AND_IF    = 4'd4;
    localparam t_kind K_PIPE      = 4'd5;
    localparam t_kind K_OR_IF     = 4'd6;
    localparam t_kind K_GT        = 4'd7;
    localparam t_kind K_GT_APPEND = 4'd8;
    localparam t_kind K_LT        = 4'd9;
    localparam t_kind K_END       = 4'd10;
    localparam t_kind K_OVERFLOW  = 4'd11;
    localparam t_kind K_LINE_DONE = 4'd12;

    // Held operator codes.
    localparam t_pend P_NONE = 2'd0;
    localparam t_pend P_AMP  = 2'd1;
    localparam t_pend P_PIPE = 2'd2;
    localparam t_pend P_GT   = 2'd3;

    // Characters of interest.
    localparam logic [7:0] C_NUL     = 8'h00;
    localparam logic [7:0] C_NEWLINE = 8'h0A;
    localparam logic [7:0] C_SPACE   = 8'h20;
    localparam logic [7:0] C_AMP     = 8'h26;
    localparam logic [7:0] C_SEMI    = 8'h3B;
    localparam logic [7:0] C_LT      = 8'h3C;
    localparam logic [7:0] C_GT      = 8'h3E;
    localparam logic [7:0] C_PIPE    = 8'h7C;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] word_byte;
        logic       last;
    } t_result;

    // Character that doubles a held operator.
    function automatic logic [7:0] op_char(input t_pend p);
        logic [7:0] c;
        case (p)
            P_AMP:   c = C_AMP;
            P_PIPE:  c = C_PIPE;
            P_GT:    c = C_GT;
            default: c = C_NUL;
        endcase
        return c;
    endfunction

    // Token for a held operator that stands alone.
    function automatic t_kind single_kind(input t_pend p);
        t_kind k;
        case (p)
            P_AMP:   k = K_AMP;
            P_PIPE:  k = K_PIPE;
            P_GT:    k = K_GT;
            default: k = K_WORD_BYTE;
        endcase
        return k;
    endfunction

    // Token for a held operator that is doubled.
    function automatic t_kind double_kind(input t_pend p);
        t_kind k;
        case (p)
            P_AMP:   k = K_AND_IF;
            P_PIPE:  k = K_OR_IF;
            P_GT:    k = K_GT_APPEND;
            default: k = K_WORD_BYTE;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/core/stok_in_if.sv =====
interface stok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

// ===== rtl/core/stok_out_if.sv =====
interface stok_out_if;
    logic             valid;
    logic             ready;
    stok_pkg::t_kind  kind;
    logic [7:0]       word_byte;
    logic             last;

    modport source (output valid, output kind, output word_byte, output last, input ready);
    modport sink   (input valid, input kind, input word_byte, input last, output ready);
endinterface

// ===== rtl/core/shell_operator_tokenizer.sv =====
// Streaming lexer for shell command lines, one byte per item.
// The input channel i_in carries char_in; the output channel o_out carries
// one token per item: kind, word_byte and last. Each input byte gives zero,
// one or two tokens, and last marks the final token caused by that byte.
// The byte is classified and the lexer state updated in the cycle it is
// accepted; its tokens go into a four-entry result queue and, if the queue
// was empty, the first of them is offered on o_out in the next cycle.
// A byte is taken in every cycle while the queue has room for two tokens,
// so bytes giving at most one token stream at one item per cycle while
// o_out.ready is high; two-token bytes are held to one token per cycle.
// When the receiver stalls, the queue fills and i_in.ready falls once fewer
// than two entries are free; nothing is lost or reordered.
// A synchronous reset (i_rst_n low) empties the queue, closes any open word,
// drops a held operator and leaves discard mode.
// MAX_WORD sets the word length at which an overflow token is given and the
// rest of the line is dropped.
module shell_operator_tokenizer #(
    parameter int MAX_WORD = stok_pkg::MAX_WORD_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    stok_in_if.sink      i_in,
    stok_out_if.source   o_out
);

    localparam int WL_W = (MAX_WORD > 2) ? $clog2(MAX_WORD) : 1;

    // Lexer state.
    logic [WL_W-1:0]     r_word_len, n_word_len;
    stok_pkg::t_pend     r_pend, n_pend;
    logic                r_disc, n_disc;

    // Result queue.
    stok_pkg::t_result   r_mem [stok_pkg::FIFO_DEPTH];
    logic [stok_pkg::FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [stok_pkg::FIFO_CW-1:0] r_count, n_count;

    stok_pkg::t_result   v_res [2];
    logic [1:0]          v_cnt;
    logic                in_acc, out_acc, take_double;
    logic [7:0]          c;

    assign c       = i_in.char_in;
    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;

    assign i_in.ready = (r_count <= stok_pkg::FIFO_CW'(stok_pkg::FIFO_DEPTH - 2));

    // Classify the byte and work out its tokens and the next lexer state.
    always_comb begin
        n_word_len  = r_word_len;
        n_pend      = r_pend;
        n_disc      = r_disc;
        v_cnt       = 2'd0;
        take_double = 1'b0;
        v_res[0]    = '0;
        v_res[1]    = '0;

        if (r_disc) begin
            if (c == stok_pkg::C_NUL) begin
                v_res[0].kind = stok_pkg::K_LINE_DONE;
                v_cnt         = 2'd1;
                n_word_len    = '0;
                n_pend        = stok_pkg::P_NONE;
                n_disc        = 1'b0;
            end
        end else begin
            // A held operator is resolved by this byte first.
            if (r_pend != stok_pkg::P_NONE) begin
                n_pend = stok_pkg::P_NONE;
                if (c == stok_pkg::op_char(r_pend)) begin
                    v_res[0].kind = stok_pkg::double_kind(r_pend);
                    take_double   = 1'b1;
                end else begin
                    v_res[0].kind = stok_pkg::single_kind(r_pend);
                end
                v_cnt = 2'd1;
            end

            if (!take_double) begin
                // Any separator or operator closes an open word.
                if (c == stok_pkg::C_NUL || c == stok_pkg::C_SPACE ||
                    c == stok_pkg::C_SEMI || c == stok_pkg::C_LT ||
                    c == stok_pkg::C_AMP || c == stok_pkg::C_PIPE ||
                    c == stok_pkg::C_GT || c == stok_pkg::C_NEWLINE) begin
                    if (r_word_len != '0) begin
                        v_res[v_cnt[0]].kind = stok_pkg::K_WORD_END;
                        v_cnt                = v_cnt + 2'd1;
                    end
                    n_word_len = '0;
                end

                case (c)
                    stok_pkg::C_NUL: begin
                        v_res[v_cnt[0]].kind = stok_pkg::K_LINE_DONE;
                        v_cnt                = v_cnt + 2'd1;
                        n_pend               = stok_pkg::P_NONE;
                        n_disc               = 1'b0;
                    end
                    stok_pkg::C_SPACE: begin
                    end
                    stok_pkg::C_SEMI: begin
                        v_res[v_cnt[0]].kind = stok_pkg::K_SEMI;
                        v_cnt                = v_cnt + 2'd1;
                    end
                    stok_pkg::C_LT: begin
                        v_res[v_cnt[0]].kind = stok_pkg::K_LT;
                        v_cnt                = v_cnt + 2'd1;
                    end
                    stok_pkg::C_AMP:  n_pend = stok_pkg::P_AMP;
                    stok_pkg::C_PIPE: n_pend = stok_pkg::P_PIPE;
                    stok_pkg::C_GT:   n_pend = stok_pkg::P_GT;
                    stok_pkg::C_NEWLINE: begin
                        v_res[v_cnt[0]].kind = stok_pkg::K_END;
                        v_cnt                = v_cnt + 2'd1;
                        n_disc               = 1'b1;
                    end
                    default: begin
                        // Word byte, or overflow once the word is full.
                        if (r_word_len == WL_W'(MAX_WORD - 1)) begin
                            v_res[v_cnt[0]].kind = stok_pkg::K_OVERFLOW;
                            n_word_len           = '0;
                            n_disc               = 1'b1;
                        end else begin
                            v_res[v_cnt[0]].kind      = stok_pkg::K_WORD_BYTE;
                            v_res[v_cnt[0]].word_byte = c;
                            n_word_len                = r_word_len + WL_W'(1);
                        end
                        v_cnt = v_cnt + 2'd1;
                    end
                endcase
            end
        end

        // Mark the final token of this byte.
        if (v_cnt == 2'd1) begin
            v_res[0].last = 1'b1;
        end
        if (v_cnt == 2'd2) begin
            v_res[1].last = 1'b1;
        end
    end

    // Lexer state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_len <= '0;
            r_pend     <= stok_pkg::P_NONE;
            r_disc     <= 1'b0;
        end else if (in_acc) begin
            r_word_len <= n_word_len;
            r_pend     <= n_pend;
            r_disc     <= n_disc;
        end
    end

    // Queue storage: up to two tokens written per accepted item.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (v_cnt != 2'd0) begin
                r_mem[r_wr_ptr] <= v_res[0];
            end
            if (v_cnt == 2'd2) begin
                r_mem[r_wr_ptr + stok_pkg::FIFO_AW'(1)] <= v_res[1];
            end
        end
    end

    assign n_count = r_count
                   + (in_acc ? stok_pkg::FIFO_CW'(v_cnt) : '0)
                   - (out_acc ? stok_pkg::FIFO_CW'(1) : '0);

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (in_acc) begin
                r_wr_ptr <= r_wr_ptr + stok_pkg::FIFO_AW'(v_cnt);
            end
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + stok_pkg::FIFO_AW'(1);
            end
            r_count <= n_count;
        end
    end

    // Head of the queue drives the output channel.
    assign o_out.valid     = (r_count != '0);
    assign o_out.kind      = r_mem[r_rd_ptr].kind;
    assign o_out.word_byte = r_mem[r_rd_ptr].word_byte;
    assign o_out.last      = r_mem[r_rd_ptr].last;

    // The queue never holds more than its depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= stok_pkg::FIFO_CW'(stok_pkg::FIFO_DEPTH))
        else $error("result queue overfilled");

    // A held operator always follows a closed word.
    a_pend_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend != stok_pkg::P_NONE) |-> (r_word_len == '0))
        else $error("operator held while a word is open");

    // Discard mode carries no open word and no held operator.
    a_disc_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_disc |-> (r_word_len == '0 && r_pend == stok_pkg::P_NONE))
        else $error("state left over in discard mode");

    // An accepted line terminator returns the lexer to its reset state.
    a_nul_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && c == stok_pkg::C_NUL) |=>
            (r_word_len == '0 && r_pend == stok_pkg::P_NONE && !r_disc))
        else $error("line end did not clear the lexer");

endmodule
